@@ hdl/d2m_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d2m_pkg: shared types and constants of the depth-to-mesh block
// Register indices and reset values, the configuration bundle and the command
// word that the front part hands to the back part through the queue.
// ----------------------------------------------------------------------------
package d2m_pkg;

    // Default frame bounds for the top-level parameters
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Field widths
    localparam int SIZE_W   = 11;
    localparam int COEF_W   = 24;
    localparam int CFG_W    = 24;
    localparam int REG_IDX_W = 3;
    localparam int DEPTH_W  = 16;
    localparam int IDX_W    = 20;
    localparam int POS_W    = 32;
    localparam int Z_W      = 31;
    // Offset magnitude |2*pos - center|; 2*pos stays below 8192 at the largest frame
    localparam int MAG_W    = 13;

    // Command queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;

    // Result kinds
    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    // Configuration register indices
    typedef enum logic [REG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_CENTER_X_HALF = 3'd2,
        REG_CENTER_Y_HALF = 3'd3,
        REG_INV_FOCAL_X   = 3'd4,
        REG_INV_FOCAL_Y   = 3'd5,
        REG_DEPTH_SCALE   = 3'd6
    } reg_index_t;

    // Reset values
    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH   = 11'd640;
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT  = 11'd480;
    localparam logic [SIZE_W-1:0] RST_CENTER_X_HALF = 11'd639;
    localparam logic [SIZE_W-1:0] RST_CENTER_Y_HALF = 11'd479;
    localparam logic [COEF_W-1:0] RST_INV_FOCAL_X   = 24'd31957;
    localparam logic [COEF_W-1:0] RST_INV_FOCAL_Y   = 24'd31957;
    localparam logic [COEF_W-1:0] RST_DEPTH_SCALE   = 24'd33554;

    typedef struct packed {
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
        logic [SIZE_W-1:0] center_x_half;
        logic [SIZE_W-1:0] center_y_half;
        logic [COEF_W-1:0] inv_focal_x;
        logic [COEF_W-1:0] inv_focal_y;
        logic [COEF_W-1:0] depth_scale;
    } d2m_cfg_t;

    // Per-pixel bookkeeping that rides along the arithmetic pipeline
    typedef struct packed {
        logic             has_tri;
        logic             neg_x;
        logic             neg_y;
        logic [IDX_W-1:0] idx_me;
        logic [IDX_W-1:0] idx_tl;
        logic [IDX_W-1:0] idx_tr;
        logic [IDX_W-1:0] idx_bl;
    } d2m_meta_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [MAG_W-1:0]   mag_x;
        logic [MAG_W-1:0]   mag_y;
        d2m_meta_t          meta;
    } d2m_cmd_t;

endpackage
`default_nettype wire

@@ hdl/d2m_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d2m_front: pixel intake and window classification
// Tracks column and row, keeps the one-bit nonzero line buffer, decides
// whether the pixel closes a fully measured 2x2 window and builds the
// vertex and corner indices; accepts a pixel, then requests until taken.
// ----------------------------------------------------------------------------
module d2m_front #(
    parameter int MAX_WIDTH  = d2m_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = d2m_pkg::MAX_HEIGHT_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  d2m_pkg::d2m_cfg_t                cfg,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [d2m_pkg::DEPTH_W-1:0]      s_depth_raw,
    output logic                             cmd_valid,
    input  wire                              cmd_ready,
    output d2m_pkg::d2m_cmd_t                cmd
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int PW  = RW + WW;
    localparam int MW1 = d2m_pkg::MAG_W + 1;
    localparam int IW  = d2m_pkg::IDX_W;

    typedef enum logic {
        ST_IDLE,
        ST_PUSH
    } state_t;

    state_t                      state_reg;
    logic [CW-1:0]               col_cnt_reg;
    logic [RW-1:0]               row_cnt_reg;
    logic                        left_nz_reg;
    logic                        ul_nz_reg;
    logic [d2m_pkg::DEPTH_W-1:0] depth_reg;
    logic [CW-1:0]               col_reg;
    logic [RW-1:0]               row_reg;
    logic [PW-1:0]               row_base_reg;
    logic                        lb_rd_reg;
    logic                        line_buf [MAX_WIDTH];

    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic           s_accept;
    logic           push;
    logic           cur_nz;
    logic           up_nz;
    logic           has_tri;
    logic [IW-1:0]  rb;
    logic [IW-1:0]  col20;
    logic [IW-1:0]  idx_me;
    logic [IW-1:0]  idx_tr;
    logic [MW1-1:0] px;
    logic [MW1-1:0] py;
    logic [MW1-1:0] cx;
    logic [MW1-1:0] cy;
    logic           neg_x;
    logic           neg_y;
    logic [MW1-1:0] dx;
    logic [MW1-1:0] dy;
    logic           wrap_col;
    logic           wrap_row;
    logic [CW-1:0]  col_cnt_next;
    logic [RW-1:0]  row_cnt_next;
    logic           left_nz_next;
    logic           ul_nz_next;

    // Clamp the frame size to 1..max
    always_comb begin
        w_eff = WW'(cfg.frame_width);
        if (cfg.frame_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end
        h_eff = HW'(cfg.frame_height);
        if (cfg.frame_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cmd_valid = (state_reg == ST_PUSH);
    assign push      = cmd_valid && cmd_ready;

    // Classify the 2x2 window ending at this pixel
    assign cur_nz  = (depth_reg != '0);
    assign up_nz   = (row_reg != '0) && lb_rd_reg;
    assign has_tri = (col_reg != '0) && (row_reg != '0) && cur_nz && left_nz_reg
                     && up_nz && ul_nz_reg;

    // Vertex and corner indices, modulo the index width
    assign rb     = IW'(row_base_reg);
    assign col20  = IW'(col_reg);
    assign idx_me = rb + col20;
    assign idx_tr = rb - IW'(w_eff) + col20;

    // Offsets from the optical center in half-pixel units
    assign px    = MW1'({col_reg, 1'b0});
    assign py    = MW1'({row_reg, 1'b0});
    assign cx    = MW1'(cfg.center_x_half);
    assign cy    = MW1'(cfg.center_y_half);
    assign neg_x = (px < cx);
    assign neg_y = (py < cy);
    assign dx    = neg_x ? (cx - px) : (px - cx);
    assign dy    = neg_y ? (cy - py) : (py - cy);

    always_comb begin
        cmd.depth        = depth_reg;
        cmd.mag_x        = dx[d2m_pkg::MAG_W-1:0];
        cmd.mag_y        = dy[d2m_pkg::MAG_W-1:0];
        cmd.meta.has_tri = has_tri;
        cmd.meta.neg_x   = neg_x;
        cmd.meta.neg_y   = neg_y;
        cmd.meta.idx_me  = idx_me;
        cmd.meta.idx_tl  = idx_tr - IW'(1);
        cmd.meta.idx_tr  = idx_tr;
        cmd.meta.idx_bl  = idx_me - IW'(1);
    end

    // Advance the scan position; wrap at the end of a row and of the frame
    always_comb begin
        wrap_col     = (32'(col_reg) + 32'd1) >= 32'(w_eff);
        wrap_row     = (32'(row_reg) + 32'd1) >= 32'(h_eff);
        col_cnt_next = wrap_col ? '0 : CW'(32'(col_reg) + 32'd1);
        row_cnt_next = row_reg;
        if (wrap_col) begin
            row_cnt_next = wrap_row ? '0 : RW'(32'(row_reg) + 32'd1);
        end
        left_nz_next = wrap_col ? 1'b0 : cur_nz;
        ul_nz_next   = wrap_col ? 1'b0 : up_nz;
    end

    // Line buffer: read the column above on accept, write it back on request
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            lb_rd_reg <= line_buf[col_cnt_reg];
        end
        if (push) begin
            line_buf[col_reg] <= cur_nz;
        end
    end

    // Intake sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            left_nz_reg <= 1'b0;
            ul_nz_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        depth_reg    <= s_depth_raw;
                        col_reg      <= col_cnt_reg;
                        row_reg      <= row_cnt_reg;
                        row_base_reg <= PW'(row_cnt_reg) * PW'(w_eff);
                        state_reg    <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (cmd_ready) begin
                        col_cnt_reg <= col_cnt_next;
                        row_cnt_reg <= row_cnt_next;
                        left_nz_reg <= left_nz_next;
                        ul_nz_reg   <= ul_nz_next;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hdl/d2m_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d2m_queue: short command queue
// Decouples the pixel front part from the arithmetic back part so that
// either one may stall while the other keeps going.
// ----------------------------------------------------------------------------
module d2m_queue (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push_valid,
    output logic                push_ready,
    input  d2m_pkg::d2m_cmd_t   push_data,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output d2m_pkg::d2m_cmd_t   pop_data
);

    localparam int DEPTH = d2m_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    d2m_pkg::d2m_cmd_t slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Store the incoming request
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/d2m_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d2m_back: back-projection pipeline and result emitter
// Five stages compute z, then x and y through split partial products with a
// floor shift; the emitter sends the vertex and, for a closed window, two
// triangles, one result per cycle unless m_ready stalls, from registers.
// ----------------------------------------------------------------------------
module d2m_back (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  d2m_pkg::d2m_cfg_t              cfg,
    input  wire                            cmd_valid,
    output logic                           cmd_ready,
    input  d2m_pkg::d2m_cmd_t              cmd,
    output logic                           m_valid,
    input  wire                            m_ready,
    output logic                           m_kind,
    output logic signed [d2m_pkg::POS_W-1:0] m_pos_x,
    output logic signed [d2m_pkg::POS_W-1:0] m_pos_y,
    output logic [d2m_pkg::Z_W-1:0]        m_pos_z,
    output logic [d2m_pkg::IDX_W-1:0]      m_index_a,
    output logic [d2m_pkg::IDX_W-1:0]      m_index_b,
    output logic [d2m_pkg::IDX_W-1:0]      m_index_c,
    output logic                           m_last
);

    localparam int ZW = d2m_pkg::Z_W;
    localparam int MW = d2m_pkg::MAG_W;
    localparam int AW = MW + ZW;        // |offset| * z
    localparam int LW = AW + 12;        // times a 12-bit half of the reciprocal
    localparam int SW = LW + 1;         // low sum
    localparam int HS = LW - 13;        // high product above the shift
    localparam int QW = AW;             // shifted magnitude
    localparam int PW = d2m_pkg::POS_W;

    typedef enum logic [1:0] {
        PH_VERT,
        PH_TRI_FIRST,
        PH_TRI_SECOND
    } phase_t;

    // Floor, saturate and sign the shifted magnitude
    function automatic logic [PW-1:0] finish_axis(input logic [QW-1:0] q,
                                                  input logic rem,
                                                  input logic neg);
        logic big;
        logic [PW-1:0] res;
        big = (q[QW-1:PW-1] != '0);
        if (!neg) begin
            res = big ? {1'b0, {(PW-1){1'b1}}} : q[PW-1:0];
        end else if (big || (rem && (q[PW-2:0] == '1))) begin
            res = {1'b1, {(PW-1){1'b0}}};
        end else begin
            res = ~q[PW-1:0] + PW'(!rem);
        end
        return res;
    endfunction

    // Pipeline stage registers
    logic                p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, p5_v_reg;
    d2m_pkg::d2m_meta_t  meta1_reg, meta2_reg, meta3_reg, meta4_reg, meta5_reg;
    logic [ZW-1:0]       z1_reg, z2_reg, z3_reg, z4_reg, z5_reg;
    logic [MW-1:0]       magx1_reg, magy1_reg;
    logic [AW-1:0]       ax2_reg, ay2_reg;
    logic [LW-1:0]       lox3_reg, hix3_reg, loy3_reg, hiy3_reg;
    logic [SW-1:0]       sx4_reg, sy4_reg;
    logic [HS-1:0]       hsx4_reg, hsy4_reg;
    logic [QW-1:0]       qx5_reg, qy5_reg;
    logic                remx5_reg, remy5_reg;

    // Emitter registers
    phase_t              phase_reg;
    logic                m_valid_reg;
    logic                m_kind_reg;
    logic [PW-1:0]       m_pos_x_reg;
    logic [PW-1:0]       m_pos_y_reg;
    logic [ZW-1:0]       m_pos_z_reg;
    logic [d2m_pkg::IDX_W-1:0] m_index_a_reg;
    logic [d2m_pkg::IDX_W-1:0] m_index_b_reg;
    logic [d2m_pkg::IDX_W-1:0] m_index_c_reg;
    logic                m_last_reg;
    d2m_pkg::d2m_meta_t  held_meta_reg;

    logic [39:0]         z_prod;
    logic [ZW-1:0]       z_sat;
    logic                load;
    logic                en;

    // Hand an item to the emitter when idle or when its last result leaves
    assign load      = p5_v_reg && (!m_valid_reg || (m_ready && m_last_reg));
    assign en        = !p5_v_reg || load;
    assign cmd_ready = en;

    // Depth times scale, shifted and saturated to 31 bits
    assign z_prod = 40'(cmd.depth) * 40'(cfg.depth_scale);
    assign z_sat  = z_prod[39] ? '1 : z_prod[38:8];

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
            p5_v_reg <= 1'b0;
        end else if (en) begin
            p1_v_reg <= cmd_valid;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            p5_v_reg <= p4_v_reg;
        end
    end

    // Stage datapath: z, offset product, split products, low sum, shifted sum
    always_ff @(posedge aclk) begin
        if (en) begin
            z1_reg    <= z_sat;
            magx1_reg <= cmd.mag_x;
            magy1_reg <= cmd.mag_y;
            meta1_reg <= cmd.meta;

            ax2_reg   <= AW'(magx1_reg) * AW'(z1_reg);
            ay2_reg   <= AW'(magy1_reg) * AW'(z1_reg);
            z2_reg    <= z1_reg;
            meta2_reg <= meta1_reg;

            lox3_reg  <= LW'(ax2_reg) * LW'(cfg.inv_focal_x[11:0]);
            hix3_reg  <= LW'(ax2_reg) * LW'(cfg.inv_focal_x[23:12]);
            loy3_reg  <= LW'(ay2_reg) * LW'(cfg.inv_focal_y[11:0]);
            hiy3_reg  <= LW'(ay2_reg) * LW'(cfg.inv_focal_y[23:12]);
            z3_reg    <= z2_reg;
            meta3_reg <= meta2_reg;

            sx4_reg   <= SW'({hix3_reg[12:0], 12'b0}) + SW'(lox3_reg);
            sy4_reg   <= SW'({hiy3_reg[12:0], 12'b0}) + SW'(loy3_reg);
            hsx4_reg  <= hix3_reg[LW-1:13];
            hsy4_reg  <= hiy3_reg[LW-1:13];
            z4_reg    <= z3_reg;
            meta4_reg <= meta3_reg;

            qx5_reg   <= QW'(hsx4_reg) + QW'(sx4_reg[SW-1:25]);
            qy5_reg   <= QW'(hsy4_reg) + QW'(sy4_reg[SW-1:25]);
            remx5_reg <= (sx4_reg[24:0] != '0);
            remy5_reg <= (sy4_reg[24:0] != '0);
            z5_reg    <= z4_reg;
            meta5_reg <= meta4_reg;
        end
    end

    // Result emitter: vertex, then the two triangles of a closed window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            phase_reg   <= PH_VERT;
        end else begin
            if (load) begin
                m_valid_reg   <= 1'b1;
                phase_reg     <= PH_VERT;
                m_kind_reg    <= d2m_pkg::KIND_VERTEX;
                m_pos_x_reg   <= finish_axis(qx5_reg, remx5_reg, meta5_reg.neg_x);
                m_pos_y_reg   <= finish_axis(qy5_reg, remy5_reg, meta5_reg.neg_y);
                m_pos_z_reg   <= z5_reg;
                m_index_a_reg <= meta5_reg.idx_me;
                m_index_b_reg <= '0;
                m_index_c_reg <= '0;
                m_last_reg    <= !meta5_reg.has_tri;
                held_meta_reg <= meta5_reg;
            end else if (m_valid_reg && m_ready) begin
                if (m_last_reg) begin
                    m_valid_reg <= 1'b0;
                end else begin
                    unique case (phase_reg)
                        PH_VERT: begin
                            phase_reg     <= PH_TRI_FIRST;
                            m_kind_reg    <= d2m_pkg::KIND_TRIANGLE;
                            m_pos_x_reg   <= '0;
                            m_pos_y_reg   <= '0;
                            m_pos_z_reg   <= '0;
                            m_index_a_reg <= held_meta_reg.idx_tl;
                            m_index_b_reg <= held_meta_reg.idx_bl;
                            m_index_c_reg <= held_meta_reg.idx_tr;
                            m_last_reg    <= 1'b0;
                        end
                        PH_TRI_FIRST: begin
                            phase_reg     <= PH_TRI_SECOND;
                            m_kind_reg    <= d2m_pkg::KIND_TRIANGLE;
                            m_pos_x_reg   <= '0;
                            m_pos_y_reg   <= '0;
                            m_pos_z_reg   <= '0;
                            m_index_a_reg <= held_meta_reg.idx_tr;
                            m_index_b_reg <= held_meta_reg.idx_bl;
                            m_index_c_reg <= held_meta_reg.idx_me;
                            m_last_reg    <= 1'b1;
                        end
                        default: begin
                            m_valid_reg <= 1'b0;
                            phase_reg   <= PH_VERT;
                        end
                    endcase
                end
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_kind    = m_kind_reg;
    assign m_pos_x   = m_pos_x_reg;
    assign m_pos_y   = m_pos_y_reg;
    assign m_pos_z   = m_pos_z_reg;
    assign m_index_a = m_index_a_reg;
    assign m_index_b = m_index_b_reg;
    assign m_index_c = m_index_c_reg;
    assign m_last    = m_last_reg;

endmodule
`default_nettype wire

@@ hdl/depth_image_to_triangle_mesh.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// depth_image_to_triangle_mesh: depth pixels to vertices and triangles
// Back-projects each depth pixel through a pinhole model into a Q16.16
// vertex and adds two triangles for every fully measured 2x2 window.
//
//   channel   direction   handshake           payload
//   s_        in          s_valid / s_ready   s_depth_raw
//   m_        out         m_valid / m_ready   m_kind, m_pos_*, m_index_*, m_last
//   cfg_wr_   in          cfg_wr_en           cfg_wr_index, cfg_wr_data
//
// The front part takes a new pixel only after the request of the last one
// enters the queue (line buffer read on accept, write-back when the request
// is taken); the emitter sends one result a cycle while m_ready is high:
// a vertex per pixel, and two triangles more when it closes a window.
// Reset is synchronous, active low; the line buffer is not cleared.
// A stalled m_ready holds the arithmetic pipeline, the 4-entry queue fills,
// then s_ready drops.
// ----------------------------------------------------------------------------
module depth_image_to_triangle_mesh #(
    parameter int MAX_WIDTH  = d2m_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = d2m_pkg::MAX_HEIGHT_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire  [d2m_pkg::REG_IDX_W-1:0]      cfg_wr_index,
    input  wire  [d2m_pkg::CFG_W-1:0]          cfg_wr_data,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [d2m_pkg::DEPTH_W-1:0]        s_depth_raw,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic                               m_kind,
    output logic signed [d2m_pkg::POS_W-1:0]   m_pos_x,
    output logic signed [d2m_pkg::POS_W-1:0]   m_pos_y,
    output logic [d2m_pkg::Z_W-1:0]            m_pos_z,
    output logic [d2m_pkg::IDX_W-1:0]          m_index_a,
    output logic [d2m_pkg::IDX_W-1:0]          m_index_b,
    output logic [d2m_pkg::IDX_W-1:0]          m_index_c,
    output logic                               m_last
);

    d2m_pkg::d2m_cfg_t cfg_reg;
    d2m_pkg::d2m_cmd_t front_cmd;
    d2m_pkg::d2m_cmd_t back_cmd;
    logic              front_valid;
    logic              front_ready;
    logic              back_valid;
    logic              back_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width   <= d2m_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height  <= d2m_pkg::RST_FRAME_HEIGHT;
            cfg_reg.center_x_half <= d2m_pkg::RST_CENTER_X_HALF;
            cfg_reg.center_y_half <= d2m_pkg::RST_CENTER_Y_HALF;
            cfg_reg.inv_focal_x   <= d2m_pkg::RST_INV_FOCAL_X;
            cfg_reg.inv_focal_y   <= d2m_pkg::RST_INV_FOCAL_Y;
            cfg_reg.depth_scale   <= d2m_pkg::RST_DEPTH_SCALE;
        end else if (cfg_wr_en) begin
            unique case (d2m_pkg::reg_index_t'(cfg_wr_index))
                d2m_pkg::REG_FRAME_WIDTH:
                    cfg_reg.frame_width <= cfg_wr_data[d2m_pkg::SIZE_W-1:0];
                d2m_pkg::REG_FRAME_HEIGHT:
                    cfg_reg.frame_height <= cfg_wr_data[d2m_pkg::SIZE_W-1:0];
                d2m_pkg::REG_CENTER_X_HALF:
                    cfg_reg.center_x_half <= cfg_wr_data[d2m_pkg::SIZE_W-1:0];
                d2m_pkg::REG_CENTER_Y_HALF:
                    cfg_reg.center_y_half <= cfg_wr_data[d2m_pkg::SIZE_W-1:0];
                d2m_pkg::REG_INV_FOCAL_X:
                    cfg_reg.inv_focal_x <= cfg_wr_data[d2m_pkg::COEF_W-1:0];
                d2m_pkg::REG_INV_FOCAL_Y:
                    cfg_reg.inv_focal_y <= cfg_wr_data[d2m_pkg::COEF_W-1:0];
                d2m_pkg::REG_DEPTH_SCALE:
                    cfg_reg.depth_scale <= cfg_wr_data[d2m_pkg::COEF_W-1:0];
                default: begin
                    // drop writes to unused indices
                end
            endcase
        end
    end

    d2m_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_depth_raw (s_depth_raw),
        .cmd_valid   (front_valid),
        .cmd_ready   (front_ready),
        .cmd         (front_cmd)
    );

    d2m_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cmd)
    );

    d2m_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_pos_x   (m_pos_x),
        .m_pos_y   (m_pos_y),
        .m_pos_z   (m_pos_z),
        .m_index_a (m_index_a),
        .m_index_b (m_index_b),
        .m_index_c (m_index_c),
        .m_last    (m_last)
    );

endmodule
`default_nettype wire
